// ----- rtl/core/bgpdf_pkg.sv -----
// Package for the BGP-4 message deframer: header layout constants,
// result kind codes and the result word type. No dependencies.
`default_nettype none

package bgpdf_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 5;
  localparam int LEN_W    = 13;
  localparam int OFFSET_W = 12;
  localparam int KIND_W   = 2;
  localparam int OUT_DATA_W = 32;

  // Header byte positions; PAYLOAD_POS marks the payload phase.
  localparam logic [POS_W-1:0] LEN_HI_POS  = POS_W'(16);
  localparam logic [POS_W-1:0] LEN_LO_POS  = POS_W'(17);
  localparam logic [POS_W-1:0] TYPE_POS    = POS_W'(18);
  localparam logic [POS_W-1:0] PAYLOAD_POS = POS_W'(19);

  localparam logic [LEN_W-1:0] HEADER_LEN = LEN_W'(19);
  localparam logic [LEN_W-1:0] LENGTH_CAP = LEN_W'(4096);

  localparam logic [BYTE_W-1:0] TYPE_FIRST = BYTE_W'(1);
  localparam logic [BYTE_W-1:0] TYPE_LAST  = BYTE_W'(4);

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [BYTE_W-1:0]    message_type;
    logic [BYTE_W-1:0]    payload_byte;
    logic [OFFSET_W-1:0]  payload_offset;
    logic                 last_of_message;
  } result_t;

  function automatic logic type_known(input logic [BYTE_W-1:0] t);
    return (t >= TYPE_FIRST) && (t <= TYPE_LAST);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bgp_message_deframer.sv -----
// BGP-4 message deframer top level: header counting, length check and
// payload byte tagging with an output register and skid stage. Uses bgpdf_pkg.
`default_nettype none

// The block takes one stream byte per word and accepts a word in every
// cycle unless the skid stage is full. The header state and the result
// are computed in the same cycle as the accept; a result is registered
// in the output register, or in the one-word skid stage when the
// output register holds an untaken word. The slave side stalls only when
// both hold a word that the master side has not yet taken. While the skid
// stage is full, every byte waits, including marker, length and
// unknown-type payload bytes that give no result.
module bgp_message_deframer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bgpdf_pkg::LEN_W-1:0]        cfg_data,   // max_message_length
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [bgpdf_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [7:0] message_type, [15:8] payload_byte, [27:16] payload_offset, [31:28] zero
  output logic [bgpdf_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic [bgpdf_pkg::KIND_W-1:0]            m_axis_tuser,  // [1:0] kind
  output logic                                    m_axis_tlast   // last_of_message
);
  import bgpdf_pkg::*;

  logic [LEN_W-1:0]  max_message_length;
  logic [POS_W-1:0]  header_position, header_position_next;
  logic [LEN_W-1:0]  message_length, message_length_next;
  logic [BYTE_W-1:0] current_type, current_type_next;
  logic [LEN_W-1:0]  payload_remaining, payload_remaining_next;

  result_t res;
  logic    res_valid;
  result_t out_word, skid_word;
  logic    out_valid, skid_valid;

  logic              accept;
  logic [POS_W-1:0]  pos;
  logic [15:0]       full_len;
  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  total;
  logic [LEN_W-1:0]  new_remaining;
  logic [LEN_W-1:0]  offset;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos = (header_position > PAYLOAD_POS) ? '0 : header_position;
    full_len = {message_length[BYTE_W-1:0], s_axis_tdata};
    limit = (max_message_length > LENGTH_CAP) ? LENGTH_CAP : max_message_length;
    total = message_length - HEADER_LEN;
    new_remaining = message_length - HEADER_LEN;
    offset = total - payload_remaining;

    header_position_next   = header_position;
    message_length_next    = message_length;
    current_type_next      = current_type;
    payload_remaining_next = payload_remaining;
    res_valid              = 1'b0;
    res.kind               = KIND_PAYLOAD;
    res.message_type       = s_axis_tdata;
    res.payload_byte       = '0;
    res.payload_offset     = '0;
    res.last_of_message    = 1'b1;

    priority if (pos < LEN_HI_POS) begin
      header_position_next = pos + POS_W'(1);
    end else if (pos == LEN_HI_POS) begin
      message_length_next  = LEN_W'(s_axis_tdata);
      header_position_next = LEN_LO_POS;
    end else if (pos == LEN_LO_POS) begin
      // A length field beyond the cap is stored as zero, which fails later.
      message_length_next  = (full_len > 16'(LENGTH_CAP)) ? '0 : full_len[LEN_W-1:0];
      header_position_next = TYPE_POS;
    end else if (pos == TYPE_POS) begin
      current_type_next = s_axis_tdata;
      if (message_length < HEADER_LEN || message_length > limit) begin
        header_position_next   = '0;
        payload_remaining_next = '0;
        res_valid              = 1'b1;
        res.kind               = KIND_ERROR;
      end else begin
        payload_remaining_next = new_remaining;
        if (new_remaining == '0) begin
          header_position_next = '0;
          res_valid            = type_known(s_axis_tdata);
          res.kind             = KIND_EMPTY;
        end else begin
          header_position_next = PAYLOAD_POS;
        end
      end
    end else begin
      if (payload_remaining == '0 || message_length < HEADER_LEN ||
          payload_remaining > total) begin
        // Inconsistent counters: this byte counts as the first marker byte.
        header_position_next   = POS_W'(1);
        payload_remaining_next = '0;
      end else begin
        payload_remaining_next = payload_remaining - LEN_W'(1);
        if (payload_remaining == LEN_W'(1)) begin
          header_position_next = '0;
        end
        res_valid           = type_known(current_type);
        res.kind            = KIND_PAYLOAD;
        res.message_type    = current_type;
        res.payload_byte    = s_axis_tdata;
        res.payload_offset  = offset[OFFSET_W-1:0];
        res.last_of_message = (payload_remaining == LEN_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= LENGTH_CAP;
      header_position    <= '0;
      message_length     <= '0;
      current_type       <= '0;
      payload_remaining  <= '0;
    end else begin
      if (cfg_we) begin
        max_message_length <= cfg_data;
      end
      if (accept) begin
        header_position   <= header_position_next;
        message_length    <= message_length_next;
        current_type      <= current_type_next;
        payload_remaining <= payload_remaining_next;
      end
    end
  end

  // Output register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && res_valid;
          if (accept && res_valid) begin
            out_word <= res;
          end
        end
      end else if (accept && res_valid) begin
        skid_valid <= 1'b1;
        skid_word  <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_word.payload_offset, out_word.payload_byte,
                          out_word.message_type};
  assign m_axis_tuser  = out_word.kind;
  assign m_axis_tlast  = out_word.last_of_message;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held while output register empty");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    header_position <= PAYLOAD_POS)
    else $error("header position out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    (header_position == PAYLOAD_POS) |-> (payload_remaining != '0))
    else $error("payload phase with no bytes remaining");

  a_end_marked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.kind != KIND_PAYLOAD) |-> out_word.last_of_message)
    else $error("end or error result without last mark");
`endif

endmodule

`default_nettype wire
